FILE: rtl/fixed_width_number_to_ascii_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef FIXED_WIDTH_NUMBER_TO_ASCII_MACROS_SVH
`define FIXED_WIDTH_NUMBER_TO_ASCII_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FWNA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FWNA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fwna_pkg.sv
`timescale 1ns / 1ps

package fwna_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_DIGITS  = 10;
  localparam int DIGITS_W    = 4 * MAX_DIGITS;
  localparam int VALUE_W     = 32;

  localparam logic [2:0] OP_DEC3 = 3'd0;
  localparam logic [2:0] OP_DEC5 = 3'd1;
  localparam logic [2:0] OP_DEC10 = 3'd2;
  localparam logic [2:0] OP_HEX2 = 3'd3;
  localparam logic [2:0] OP_HEX4 = 3'd4;

  localparam logic [6:0] ASCII_ZERO = 7'h30;
  localparam logic [6:0] ASCII_LOWA = 7'h61;

  typedef struct packed {
    logic               is_hex;
    logic [3:0]         ndigits;
    logic [5:0]         nbits;    // conversion steps, zero for hex
    logic [VALUE_W-1:0] value;    // decimal: msb aligned; hex: lsb aligned
  } job_t;

  typedef struct packed {
    logic idle;
    logic pop;
    logic load;
    logic load_last;
  } bstat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } bstate_t;

  // add 3 to every BCD digit of 5 or more
  function automatic logic [DIGITS_W-1:0] bcd_adjust(input logic [DIGITS_W-1:0] x);
    logic [DIGITS_W-1:0] r;
    r = x;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (x[4*k +: 4] >= 4'd5) begin
        r[4*k +: 4] = x[4*k +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] nib_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return ASCII_ZERO + {3'b000, nib};
    end
    return ASCII_LOWA + {3'b000, nib} - 7'd10;
  endfunction

endpackage

FILE: rtl/fwna_if.sv
`timescale 1ns / 1ps

interface fwna_num_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink (input valid, input opcode, input value, output ready);
endinterface

interface fwna_text_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink (input valid, input char_code, input last, output ready);
endinterface

FILE: rtl/fwna_front.sv
`timescale 1ns / 1ps

module fwna_front (
  fwna_num_if.sink       num,
  input  logic           q_full,
  output logic           push,
  output fwna_pkg::job_t job
);

  logic legal;

  always_comb begin
    legal = 1'b1;
    job   = '0;
    case (num.opcode)
      fwna_pkg::OP_DEC3: begin
        job.ndigits = 4'd3;
        job.nbits   = 6'd8;
        job.value   = {num.value[7:0], 24'd0};
      end
      fwna_pkg::OP_DEC5: begin
        job.ndigits = 4'd5;
        job.nbits   = 6'd16;
        job.value   = {num.value[15:0], 16'd0};
      end
      fwna_pkg::OP_DEC10: begin
        job.ndigits = 4'd10;
        job.nbits   = 6'd32;
        job.value   = num.value;
      end
      fwna_pkg::OP_HEX2: begin
        job.is_hex  = 1'b1;
        job.ndigits = 4'd2;
        job.value   = {24'd0, num.value[7:0]};
      end
      fwna_pkg::OP_HEX4: begin
        job.is_hex  = 1'b1;
        job.ndigits = 4'd4;
        job.value   = {16'd0, num.value[15:0]};
      end
      default: begin
        legal = 1'b0;  // drop unknown formats
      end
    endcase
  end

  assign num.ready = !q_full;
  assign push      = num.valid && !q_full && legal;

endmodule

FILE: rtl/fwna_queue.sv
`timescale 1ns / 1ps

module fwna_queue #(
  parameter int DEPTH = fwna_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fwna_pkg::job_t wr_job,
  input  logic           pop,
  output fwna_pkg::job_t head,
  output logic           empty,
  output logic           full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fwna_pkg::job_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));

endmodule

FILE: rtl/fwna_back.sv
`timescale 1ns / 1ps

module fwna_back (
  input  logic              clk,
  input  logic              rst,
  input  fwna_pkg::job_t    head,
  input  logic              empty,
  output fwna_pkg::bstat_t  stat,
  fwna_text_if.source       text
);

  fwna_pkg::bstate_t state, state_next;

  logic [fwna_pkg::DIGITS_W-1:0] digits, digits_next;
  logic [fwna_pkg::VALUE_W-1:0]  val, val_next;
  logic [5:0]                    cnt, cnt_next;
  logic [3:0]                    idx, idx_next;
  logic                          ovalid, ovalid_next;
  logic [6:0]                    ochar, ochar_next;
  logic                          olast, olast_next;

  logic [fwna_pkg::DIGITS_W-1:0] adj;
  logic [3:0]                    nib;
  logic                          can_load;

  assign adj      = fwna_pkg::bcd_adjust(digits);
  assign nib      = digits[{idx, 2'b00} +: 4];
  assign can_load = !ovalid || text.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= fwna_pkg::ST_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    digits <= digits_next;
    val    <= val_next;
    cnt    <= cnt_next;
    idx    <= idx_next;
    ochar  <= ochar_next;
    olast  <= olast_next;
  end

  always_comb begin
    state_next  = state;
    digits_next = digits;
    val_next    = val;
    cnt_next    = cnt;
    idx_next    = idx;
    ochar_next  = ochar;
    olast_next  = olast;
    ovalid_next = ovalid && !text.ready;
    stat        = '0;
    stat.idle   = (state == fwna_pkg::ST_IDLE);

    case (state)
      fwna_pkg::ST_IDLE: begin
        if (!empty) begin
          stat.pop    = 1'b1;
          digits_next = head.is_hex ? {8'd0, head.value} : '0;
          val_next    = head.value;
          cnt_next    = head.nbits;
          idx_next    = head.ndigits - 4'd1;
          state_next  = head.is_hex ? fwna_pkg::ST_EMIT : fwna_pkg::ST_CONV;
        end
      end
      fwna_pkg::ST_CONV: begin
        // shift-and-add-3, one value bit per cycle, msb first
        {digits_next, val_next} = {adj, val} << 1;
        cnt_next = cnt - 6'd1;
        if (cnt == 6'd1) begin
          state_next = fwna_pkg::ST_EMIT;
        end
      end
      fwna_pkg::ST_EMIT: begin
        if (can_load) begin
          stat.load      = 1'b1;
          stat.load_last = (idx == 4'd0);
          ovalid_next    = 1'b1;
          ochar_next     = fwna_pkg::nib_char(nib);
          olast_next     = (idx == 4'd0);
          if (idx == 4'd0) begin
            state_next = fwna_pkg::ST_IDLE;
          end else begin
            idx_next = idx - 4'd1;
          end
        end
      end
      default: begin
        state_next = fwna_pkg::ST_IDLE;
      end
    endcase
  end

  assign text.valid     = ovalid;
  assign text.char_code = ochar;
  assign text.last      = olast;

endmodule

FILE: rtl/fixed_width_number_to_ascii.sv
`timescale 1ns / 1ps
// Channel  Role    Word
// num      sink    opcode[2:0], value[31:0]
// text     source  char_code[6:0], last
//
// Per number, the back end takes it from the queue, then shifts each value bit
// through the shift-and-add-3 unit (8, 16 or 32, none for hex), then emits each character.
// A queue of QUEUE_DEPTH numbers lets num keep flowing while text stalls.
// Unknown format codes are accepted and dropped. Reset is synchronous, active high.

`include "fixed_width_number_to_ascii_macros.svh"

module fixed_width_number_to_ascii #(
  parameter int QUEUE_DEPTH = fwna_pkg::QUEUE_DEPTH
) (
  input logic          clk,
  input logic          rst,
  fwna_num_if.sink     num,
  fwna_text_if.source  text
);

  fwna_pkg::job_t   job;
  fwna_pkg::job_t   head;
  fwna_pkg::bstat_t stat;
  logic             push;
  logic             q_empty;
  logic             q_full;

  fwna_front u_front (
    .num    (num),
    .q_full (q_full),
    .push   (push),
    .job    (job)
  );

  fwna_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_job (job),
    .pop    (stat.pop),
    .head   (head),
    .empty  (q_empty),
    .full   (q_full)
  );

  fwna_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (q_empty),
    .stat  (stat),
    .text  (text)
  );

  `FWNA_ASSERT_NOW(a_pop_when_idle, stat.pop, stat.idle && !q_empty, "pop while busy or empty")
  `FWNA_ASSERT_NEXT(a_last_frees_back, stat.load_last, stat.idle, "back busy after last char")
  `FWNA_ASSERT_NEXT(a_push_fills_queue, push && !stat.pop, !q_empty, "pushed word lost")
  `FWNA_ASSERT_NEXT(a_load_shows_word, stat.load, text.valid, "loaded char not shown")

endmodule
